@@ src/tsrb_pkg.sv @@
// tsrb_pkg: shared types and constants for the timestamp reorder buffer
// transaction structs, operation and register codes, cell command type
// no dependencies
`timescale 1ns / 1ps

package tsrb_pkg;

  // default build constants
  localparam int unsigned DefCapacity    = 64;
  localparam int unsigned DefHandleWidth = 32;

  // fixed field widths
  localparam int unsigned StampW    = 64;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned OccW      = 7;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 64;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_ORDER_DELAY    = CfgIndexW'(0);
  localparam logic [CfgIndexW-1:0] REG_CAPACITY_LIMIT = CfgIndexW'(1);

  // input operations
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_SET_WM = 2'd1,
    OP_FINISH = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  // what every cell does with its slot, chosen by the broadcast command
  typedef enum logic [1:0] {
    CM_HOLD        = 2'd0,
    CM_SHIFT       = 2'd1,
    CM_INSERT      = 2'd2,
    CM_DROP_INSERT = 2'd3
  } cell_mode_e;

  // broadcast command to the cell row
  typedef struct packed {
    cell_mode_e          mode;
    logic [StampW-1:0]   stamp;
  } cell_cmd_t;

  // input transaction
  typedef struct packed {
    op_e                 operation;
    logic [StampW-1:0]   stamp;
    logic [PayloadW-1:0] payload;
  } tsrb_in_t;

  // output transaction
  typedef struct packed {
    logic                item_valid;
    logic [StampW-1:0]   item_stamp;
    logic [PayloadW-1:0] item_handle;
    logic                dropped;
    logic [OccW-1:0]     occupancy;
    logic [OccW-1:0]     peak_occupancy;
    logic                drained;
  } tsrb_out_t;

endpackage

@@ src/tsrb_cell.sv @@
// tsrb_cell: one slot of the sorted cell row, holds a stamp and a handle
// takes entries from its left or right neighbor as the broadcast command selects
// depends on tsrb_pkg
`timescale 1ns / 1ps

module tsrb_cell #(
  parameter int unsigned HANDLE_W = 32,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned IDX      = 0
) (
  input  logic                         clk_i,
  input  tsrb_pkg::cell_cmd_t          cmd_i,
  input  logic [HANDLE_W-1:0]          new_handle_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [tsrb_pkg::StampW-1:0]  left_stamp_i,
  input  logic [HANDLE_W-1:0]          left_handle_i,
  input  logic                         left_le_i,
  input  logic [tsrb_pkg::StampW-1:0]  right_stamp_i,
  input  logic [HANDLE_W-1:0]          right_handle_i,
  input  logic                         right_le_i,
  output logic [tsrb_pkg::StampW-1:0]  stamp_o,
  output logic [HANDLE_W-1:0]          handle_o,
  output logic                         le_o
);
  import tsrb_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx   = CNT_W'(IDX);
  localparam bit               IsFirst = (IDX == 0);

  logic [StampW-1:0]   stamp_q, stamp_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic                occupied;

  // slot holds a live entry that sorts at or before the new stamp
  assign occupied = MyIdx < count_i;
  assign le_o     = occupied && (stamp_q <= cmd_i.stamp);
  assign stamp_o  = stamp_q;
  assign handle_o = handle_q;

  // next entry from own slot, a neighbor or the incoming item
  always_comb begin
    stamp_d  = stamp_q;
    handle_d = handle_q;
    unique case (cmd_i.mode)
      CM_HOLD: begin
      end
      CM_SHIFT: begin
        stamp_d  = right_stamp_i;
        handle_d = right_handle_i;
      end
      CM_INSERT: begin
        if (le_o) begin
        end else if (IsFirst || left_le_i) begin
          stamp_d  = cmd_i.stamp;
          handle_d = new_handle_i;
        end else begin
          stamp_d  = left_stamp_i;
          handle_d = left_handle_i;
        end
      end
      CM_DROP_INSERT: begin
        if (right_le_i) begin
          stamp_d  = right_stamp_i;
          handle_d = right_handle_i;
        end else if (IsFirst || le_o) begin
          stamp_d  = cmd_i.stamp;
          handle_d = new_handle_i;
        end
      end
      default: begin
      end
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    stamp_q  <= stamp_d;
    handle_q <= handle_d;
  end

endmodule

@@ src/timestamp_reorder_buffer.sv @@
// timestamp_reorder_buffer: bounded buffer releasing trace items in stamp order
// control, configuration and output register around a row of tsrb_cell
// depends on tsrb_pkg and tsrb_cell
`timescale 1ns / 1ps

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o    tsrb_in_t
// out      output     out_valid_o / out_stall_i  tsrb_out_t
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one transaction per cycle while in_stall_o is low; its result sits in the output register from the next cycle
// every push, pop or shift is done by the cell row in parallel, one compare per cell
// reset clears counters, watermark, flush flag, configuration registers and output valid; entries need no clearing
// in_stall_o is high only while a result is held and out_stall_i is high

module timestamp_reorder_buffer #(
  parameter int unsigned CAPACITY     = tsrb_pkg::DefCapacity,
  parameter int unsigned HANDLE_WIDTH = tsrb_pkg::DefHandleWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tsrb_pkg::tsrb_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tsrb_pkg::tsrb_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsrb_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [tsrb_pkg::CfgDataW-1:0]   cfg_data_i
);
  import tsrb_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned HW    = (HANDLE_WIDTH < PayloadW) ? HANDLE_WIDTH : PayloadW;
  localparam int unsigned LW    = (CNT_W > OccW) ? CNT_W : OccW;
  localparam logic [LW-1:0] CapL = LW'(CAPACITY);

  // control and configuration state
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [StampW-1:0] wm_q, wm_d;
  logic              flush_q, flush_d;
  logic [StampW-1:0] delay_q;
  logic [OccW-1:0]   limit_q;
  logic              out_valid_q;
  tsrb_out_t         out_q, out_d;

  logic              accept;
  logic              drop;
  logic              release_item;
  logic [StampW-1:0] thr;
  logic [LW-1:0]     eff_limit;
  logic [LW-1:0]     count_ext, count_d_ext, peak_d_ext;
  cell_cmd_t         cmd;
  logic [HW-1:0]     new_handle;

  // cell row wiring
  logic [StampW-1:0] cell_stamp  [CAPACITY];
  logic [HW-1:0]     cell_handle [CAPACITY];
  logic              cell_le     [CAPACITY];

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ORDER_DELAY:    delay_q <= cfg_data_i;
        REG_CAPACITY_LIMIT: limit_q <= cfg_data_i[OccW-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective limit, drop and release decisions
  assign eff_limit = ((limit_q == '0) || (LW'(limit_q) > CapL)) ? CapL : LW'(limit_q);
  assign count_ext = LW'(count_q);
  assign drop      = count_ext >= eff_limit;
  assign thr       = (wm_q > delay_q) ? (wm_q - delay_q) : '0;
  assign release_item = (count_q != '0) && (flush_q || (cell_stamp[0] <= thr));
  assign new_handle   = in_data_i.payload[HW-1:0];

  // cell command
  always_comb begin
    cmd.stamp = in_data_i.stamp;
    cmd.mode  = CM_HOLD;
    if (accept) begin
      unique case (in_data_i.operation)
        OP_PUSH:   cmd.mode = drop ? CM_DROP_INSERT : CM_INSERT;
        OP_POP:    cmd.mode = release_item ? CM_SHIFT : CM_HOLD;
        OP_SET_WM: cmd.mode = CM_HOLD;
        OP_FINISH: cmd.mode = CM_HOLD;
        default:   cmd.mode = CM_HOLD;
      endcase
    end
  end

  // next control state and result
  always_comb begin
    count_d = count_q;
    peak_d  = peak_q;
    wm_d    = wm_q;
    flush_d = flush_q;
    out_d   = '0;
    if (accept) begin
      unique case (in_data_i.operation)
        OP_PUSH: begin
          if (!drop) begin
            count_d = count_q + CNT_W'(1);
          end
          out_d.dropped = drop;
        end
        OP_SET_WM: wm_d    = in_data_i.stamp;
        OP_FINISH: flush_d = 1'b1;
        OP_POP: begin
          if (release_item) begin
            count_d           = count_q - CNT_W'(1);
            out_d.item_valid  = 1'b1;
            out_d.item_stamp  = cell_stamp[0];
            out_d.item_handle = PayloadW'(cell_handle[0]);
          end
        end
        default: begin
        end
      endcase
      if (count_d > peak_q) begin
        peak_d = count_d;
      end
    end
    count_d_ext          = LW'(count_d);
    peak_d_ext           = LW'(peak_d);
    out_d.occupancy      = count_d_ext[OccW-1:0];
    out_d.peak_occupancy = peak_d_ext[OccW-1:0];
    out_d.drained        = flush_d && (count_d == '0);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
      wm_q    <= '0;
      flush_q <= 1'b0;
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      wm_q    <= wm_d;
      flush_q <= flush_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sorted cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [StampW-1:0] l_stamp, r_stamp;
    logic [HW-1:0]     l_handle, r_handle;
    logic              l_le, r_le;

    if (g == 0) begin : g_left_end
      assign l_stamp  = '0;
      assign l_handle = '0;
      assign l_le     = 1'b0;
    end else begin : g_left
      assign l_stamp  = cell_stamp[g-1];
      assign l_handle = cell_handle[g-1];
      assign l_le     = cell_le[g-1];
    end

    if (g == CAPACITY - 1) begin : g_right_end
      assign r_stamp  = '0;
      assign r_handle = '0;
      assign r_le     = 1'b0;
    end else begin : g_right
      assign r_stamp  = cell_stamp[g+1];
      assign r_handle = cell_handle[g+1];
      assign r_le     = cell_le[g+1];
    end

    tsrb_cell #(
      .HANDLE_W (HW),
      .CNT_W    (CNT_W),
      .IDX      (g)
    ) u_cell (
      .clk_i          (clk_i),
      .cmd_i          (cmd),
      .new_handle_i   (new_handle),
      .count_i        (count_q),
      .left_stamp_i   (l_stamp),
      .left_handle_i  (l_handle),
      .left_le_i      (l_le),
      .right_stamp_i  (r_stamp),
      .right_handle_i (r_handle),
      .right_le_i     (r_le),
      .stamp_o        (cell_stamp[g]),
      .handle_o       (cell_handle[g]),
      .le_o           (cell_le[g])
    );
  end

  // occupancy never exceeds the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // peak tracks occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q)
    else $error("peak below occupancy");

  // flush mode is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |=> flush_q)
    else $error("flush mode cleared");

  // a release removes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.operation == OP_POP) && release_item)
      |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("release did not remove one entry");

  // a push without drop adds exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.operation == OP_PUSH) && !drop)
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not add one entry");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for timestamp_reorder_buffer, random and directed transactions
// a scoreboard class predicts each result in stamp order, plain tasks drive the ports
// depends on tsrb_pkg and the timestamp_reorder_buffer rtl
`timescale 1ns / 1ps

module tb;
  import tsrb_pkg::*;

  localparam int unsigned LongHold = 300;
  localparam int unsigned PhaseLen = 230;

  // predicts occupancy, drops and releases of the sorted entry row
  class reorder_scoreboard;
    logic [StampW-1:0]   stamp_row [DefCapacity];
    logic [PayloadW-1:0] handle_row [DefCapacity];
    int unsigned         fill;
    int unsigned         peak;
    logic [StampW-1:0]   wmark;
    logic [StampW-1:0]   delay;
    logic [OccW-1:0]     limit;
    bit                  flushing;
    tsrb_out_t           pending_q[$];
    int unsigned         failures;
    int unsigned         reported;

    function new();
      fill = 0;
      peak = 0;
      wmark = '0;
      delay = '0;
      limit = '0;
      flushing = 1'b0;
      failures = 0;
      reported = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("tb: %s", msg);
      end
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == REG_ORDER_DELAY) begin
        delay = data;
      end else if (idx == REG_CAPACITY_LIMIT) begin
        limit = data[OccW-1:0];
      end
    endfunction

    // remove the oldest entry, moving the rest up one slot
    function void shift_out();
      for (int i = 1; i < fill; i++) begin
        stamp_row[i-1]  = stamp_row[i];
        handle_row[i-1] = handle_row[i];
      end
      if (fill > 0) fill--;
    endfunction

    // accepted input transaction: update state and queue the expected result
    function void note_input(tsrb_in_t t);
      tsrb_out_t         res;
      int unsigned       lim;
      int unsigned       pos;
      logic [StampW-1:0] thr;
      res = '0;
      case (t.operation)
        OP_PUSH: begin
          lim = (limit == 0 || limit > DefCapacity) ? DefCapacity : int'(limit);
          if (fill >= lim) begin
            shift_out();
            res.dropped = 1'b1;
          end
          if (fill < DefCapacity) begin
            // insert after every entry with a stamp not above the new one
            pos = fill;
            while (pos > 0 && stamp_row[pos-1] > t.stamp) begin
              stamp_row[pos]  = stamp_row[pos-1];
              handle_row[pos] = handle_row[pos-1];
              pos--;
            end
            stamp_row[pos]  = t.stamp;
            handle_row[pos] = t.payload;
            fill++;
          end
          if (fill > peak) peak = fill;
        end
        OP_SET_WM: wmark = t.stamp;
        OP_FINISH: flushing = 1'b1;
        default: begin
          thr = (wmark > delay) ? wmark - delay : '0;
          if (fill > 0 && (flushing || stamp_row[0] <= thr)) begin
            res.item_valid  = 1'b1;
            res.item_stamp  = stamp_row[0];
            res.item_handle = handle_row[0];
            shift_out();
          end
        end
      endcase
      res.occupancy      = OccW'(fill);
      res.peak_occupancy = OccW'(peak);
      res.drained        = flushing && (fill == 0);
      pending_q = {pending_q, res};
    endfunction

    // accepted output transaction against the oldest expectation
    function void check_result(tsrb_out_t got);
      tsrb_out_t exp;
      if (pending_q.size() == 0) begin
        note_failure("result with no transaction outstanding");
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        note_failure($sformatf(
          "mismatch exp v=%0b s=%h h=%h d=%0b occ=%0d pk=%0d dr=%0b got v=%0b s=%h h=%h %s",
          exp.item_valid, exp.item_stamp, exp.item_handle, exp.dropped, exp.occupancy,
          exp.peak_occupancy, exp.drained, got.item_valid, got.item_stamp, got.item_handle,
          $sformatf("d=%0b occ=%0d pk=%0d dr=%0b", got.dropped, got.occupancy,
                    got.peak_occupancy, got.drained)));
      end
    endfunction

    function void close_out();
      if (pending_q.size() != 0) begin
        note_failure($sformatf("%0d results never arrived", pending_q.size()));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  tsrb_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  tsrb_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  reorder_scoreboard    sb;
  bit                   hold_req;
  logic [StampW-1:0]    time_base;
  logic [StampW-1:0]    last_stamp;

  timestamp_reorder_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int seg;
    int pct;
    bit hold_done;
    out_stall = 1'b0;
    seg = 0;
    pct = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (LongHold - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 20;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        seg--;
        out_stall = ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic tsrb_in_t make_txn(op_e op, logic [StampW-1:0] stamp,
                                        logic [PayloadW-1:0] payload);
    tsrb_in_t t;
    t.operation = op;
    t.stamp     = stamp;
    t.payload   = payload;
    return t;
  endfunction

  // random transaction; most stamps cluster around a slowly advancing base
  function automatic tsrb_in_t rand_item(int push_pct, int pop_pct, int fin_pct);
    tsrb_in_t t;
    int       roll;
    t.stamp   = {$urandom, $urandom};
    t.payload = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < fin_pct) begin
      t.operation = OP_FINISH;
    end else if (roll < fin_pct + push_pct) begin
      t.operation = OP_PUSH;
      case ($urandom_range(0, 9))
        0: ;
        1: t.stamp = last_stamp;
        default: t.stamp = time_base + $urandom_range(0, 400);
      endcase
      last_stamp = t.stamp;
    end else if (roll < fin_pct + push_pct + pop_pct) begin
      t.operation = OP_POP;
    end else begin
      t.operation = OP_SET_WM;
      if ($urandom_range(0, 15) != 0) t.stamp = time_base + $urandom_range(0, 300);
      time_base = time_base + $urandom_range(0, 80);
    end
    return t;
  endfunction

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(tsrb_in_t t);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bursts of random length with random gaps; with pressure, a long receiver hold-off and a mid-phase drain
  task automatic run_phase(int count, int push_pct, int pop_pct, int fin_pct, bit pressure);
    int burst;
    burst = 0;
    for (int sent = 0; sent < count; sent++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      end
      burst--;
      if (pressure && sent == count / 4) hold_req = 1'b1;
      if (pressure && sent == count / 2) wait_drained();
      send_item(rand_item(push_pct, pop_pct, fin_pct));
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [CfgDataW-1:0] limit_word;
    sb = new();
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ORDER_DELAY;
    cfg_data   = '0;
    hold_req   = 1'b0;
    time_base  = '0;
    last_stamp = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    write_reg(REG_ORDER_DELAY, '0);
    write_reg(REG_CAPACITY_LIMIT, '0);

    // empty pop, stamp extremes, ties, not-ready pop, watermark release
    send_item(make_txn(OP_POP, '1, '1));
    send_item(make_txn(OP_PUSH, '0, '0));
    send_item(make_txn(OP_PUSH, '1, '1));
    send_item(make_txn(OP_PUSH, 64'd100, 32'd1));
    send_item(make_txn(OP_PUSH, 64'd100, 32'd2));
    send_item(make_txn(OP_PUSH, 64'd100, 32'd3));
    send_item(make_txn(OP_POP, '0, '0));
    send_item(make_txn(OP_POP, '0, '0));
    send_item(make_txn(OP_SET_WM, 64'd100, '1));
    send_item(make_txn(OP_POP, '1, '0));
    send_item(make_txn(OP_POP, '0, '1));
    send_item(make_txn(OP_SET_WM, '1, '0));
    send_item(make_txn(OP_POP, '0, '0));
    send_item(make_txn(OP_POP, '0, '0));
    send_item(make_txn(OP_POP, '0, '0));
    wait_drained();

    // tiny limit drops the oldest; delay above watermark floors threshold at zero
    write_reg(REG_ORDER_DELAY, '1);
    write_reg(REG_CAPACITY_LIMIT, 64'd2);
    send_item(make_txn(OP_PUSH, 64'd7, 32'h5555_5555));
    send_item(make_txn(OP_PUSH, 64'd3, 32'haaaa_aaaa));
    send_item(make_txn(OP_PUSH, 64'd5, 32'h0000_0001));
    send_item(make_txn(OP_PUSH, 64'd1, 32'h8000_0000));
    send_item(make_txn(OP_POP, '0, '0));
    send_item(make_txn(OP_SET_WM, '0, '0));
    send_item(make_txn(OP_POP, '0, '0));
    wait_drained();

    // random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      limit_word = {$urandom, $urandom};
      case (p)
        0: begin
          write_reg(REG_ORDER_DELAY, '0);
          limit_word[OccW-1:0] = '0;
        end
        1: begin
          write_reg(REG_ORDER_DELAY, 64'd10);
          limit_word[OccW-1:0] = OccW'(64);
        end
        2: begin
          write_reg(REG_ORDER_DELAY, 64'd50);
          limit_word[OccW-1:0] = OccW'(8);
        end
        3: begin
          write_reg(REG_ORDER_DELAY, '1);
          limit_word[OccW-1:0] = OccW'(1);
        end
        4: begin
          write_reg(REG_ORDER_DELAY, 64'($urandom_range(0, 1000)));
          limit_word[OccW-1:0] = OccW'(100);
        end
        5: begin
          // limit well under the occupancy left by the fill-heavy phase before
          write_reg(REG_ORDER_DELAY, '0);
          limit_word[OccW-1:0] = OccW'(3);
        end
        6: begin
          time_base = 64'hffff_ffff_ffff_fe00;
          write_reg(REG_ORDER_DELAY, {$urandom, $urandom});
          limit_word[OccW-1:0] = '1;
        end
        default: begin
          write_reg(REG_ORDER_DELAY, 64'd5);
          limit_word[OccW-1:0] = OccW'($urandom_range(0, 64));
        end
      endcase
      write_reg(REG_CAPACITY_LIMIT, limit_word);
      case (p)
        0: run_phase(PhaseLen, 65, 20, 0, 1'b0);
        1: run_phase(PhaseLen, 45, 40, 0, 1'b1);
        4: run_phase(PhaseLen, 70, 15, 0, 1'b0);
        5: run_phase(PhaseLen, 40, 45, 0, 1'b0);
        // flush is sticky, so finish only shows up in the last phase
        7: run_phase(PhaseLen, 50, 35, 3, 1'b0);
        default: run_phase(PhaseLen, 45, 40, 0, 1'b0);
      endcase
      wait_drained();
    end

    sb.close_out();
    if (sb.failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tsrb_pkg.sv
src/tsrb_cell.sv
src/timestamp_reorder_buffer.sv
bench/tb.sv
